// File: rtl/core/sal_pkg.sv
// Types and codes shared by the sorted array list and its storage cells.
package sal_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  // Request opcodes.
  localparam logic [OpW-1:0] OpInsert = 3'd0;
  localparam logic [OpW-1:0] OpDelete = 3'd1;
  localparam logic [OpW-1:0] OpClear  = 3'd2;
  localparam logic [OpW-1:0] OpRewind = 3'd3;
  localparam logic [OpW-1:0] OpNext   = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;
  localparam logic [StatusW-1:0] StPastEnd  = 2'd3;

  // One request item.
  typedef struct packed {
    logic [OpW-1:0]           opcode;
    logic signed [ValueW-1:0] value;
  } req_t;

  // One result item.
  typedef struct packed {
    logic signed [ValueW-1:0] item_out;
    logic [CountW-1:0]        count;
    logic                     full_res;
    logic [StatusW-1:0]       status;
  } rsp_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/core/sorted_array_list.sv
// Top level of the sorted array list: request decode, cell row and result register.
//
// Usage: requests arrive on the in channel (in_valid_i, in_stall_o, in_item_i),
// each carrying an opcode and a signed value. Every request yields exactly one
// result item on the out channel (out_valid_o, out_stall_i, out_item_o) that
// reports the entry read, the entry count, a full flag and a status code.
// A row of CAPACITY cells holds the entries in ascending order; all cells
// compare against the request value and shift with their neighbours at once,
// so a request is finished in the cycle it is accepted.
// The result is presented from the result register in the cycle after acceptance,
// and the block takes one request per cycle while no result waits on a stalled
// receiver. The pass through the cell row and its delete match chain is combinational.
// While a result waits on a stalled receiver, in_stall_o is raised and no new
// request is taken; the result item is held unchanged until it is taken.
// Reset empties the list, rewinds the read cursor and drops any pending
// result. Entry storage is not cleared; only entries below the count are read.
module sorted_array_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sal_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sal_pkg::rsp_t out_item_o
);
  import sal_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic                     accept;
  cell_cmd_t                cmd;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          cursor_q, cursor_d;
  logic                     out_valid_q, out_valid_d;
  rsp_t                     out_q, out_d;
  logic [CAPACITY-1:0]      occ;
  logic [CAPACITY-1:0]      shift_w;
  logic [CAPACITY-1:0]      found_w;
  logic signed [ValueW-1:0] entry_w [CAPACITY];
  logic                     is_full;
  logic                     can_read;

  // A new request is taken unless a result is still waiting on the receiver.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign can_read = (cursor_q < count_q);

  // Broadcast command to the cell row. A delete with no match leaves every
  // cell alone, since no cell raises its found flag.
  always_comb begin
    cmd.value  = in_item_i.value;
    cmd.ins_en = accept && (in_item_i.opcode == OpInsert) && !is_full;
    cmd.del_en = accept && (in_item_i.opcode == OpDelete);
  end

  // Row of cells with neighbour links.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                     prev_shift;
    logic                     prev_found;
    logic signed [ValueW-1:0] prev_entry;
    logic signed [ValueW-1:0] next_entry;

    assign occ[k] = (CntW'(k) < count_q);

    if (k == 0) begin : g_first
      assign prev_shift = 1'b0;
      assign prev_found = 1'b0;
      assign prev_entry = '0;
    end else begin : g_inner
      assign prev_shift = shift_w[k-1];
      assign prev_found = found_w[k-1];
      assign prev_entry = entry_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign next_entry = entry_w[k];
    end else begin : g_upper
      assign next_entry = entry_w[k+1];
    end

    sal_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[k]),
      .prev_shift_i (prev_shift),
      .prev_found_i (prev_found),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[k]),
      .shift_o      (shift_w[k]),
      .found_o      (found_w[k])
    );
  end

  // Request decode: count, cursor and the result item.
  always_comb begin
    logic [CntW-1:0] cnt_next;
    cnt_next       = count_q;
    cursor_d       = cursor_q;
    out_d          = out_q;
    out_d.item_out = '0;
    out_d.status   = StOk;
    unique case (in_item_i.opcode)
      OpInsert: begin
        if (is_full) begin
          out_d.status = StFull;
        end else begin
          cnt_next = count_q + CntW'(1);
        end
      end
      OpDelete: begin
        if (found_w[CAPACITY-1]) begin
          cnt_next = count_q - CntW'(1);
        end else begin
          out_d.status = StNotFound;
        end
      end
      OpClear: begin
        cnt_next = '0;
      end
      OpRewind: begin
        cursor_d = '0;
      end
      OpNext: begin
        if (can_read) begin
          out_d.item_out = entry_w[cursor_q[IdxW-1:0]];
          cursor_d       = cursor_q + CntW'(1);
        end else begin
          out_d.status = StPastEnd;
        end
      end
      default: begin
      end
    endcase
    out_d.count    = CountW'(cnt_next);
    out_d.full_res = (cnt_next == CntW'(CAPACITY));
    count_d        = cnt_next;
  end

  // Result valid flag: set on acceptance, cleared once the item is taken.
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/sal_cell.sv
// One storage cell of the sorted list: holds a single entry and its neighbour links.
module sal_cell (
  input  logic                             clk_i,
  input  sal_pkg::cell_cmd_t               cmd_i,
  input  logic                             occ_i,
  input  logic                             prev_shift_i,
  input  logic                             prev_found_i,
  input  logic signed [sal_pkg::ValueW-1:0] prev_entry_i,
  input  logic signed [sal_pkg::ValueW-1:0] next_entry_i,
  output logic signed [sal_pkg::ValueW-1:0] entry_o,
  output logic                             shift_o,
  output logic                             found_o
);
  import sal_pkg::*;

  logic signed [ValueW-1:0] entry_q, entry_d;

  // This cell lies at or beyond the insert point when it is empty or holds a
  // larger value; the list is sorted, so this flag is monotonic along the row.
  assign shift_o = !occ_i || (cmd_i.value < entry_q);

  // The first matching entry and all cells above it take part in a delete.
  assign found_o = prev_found_i || (occ_i && (cmd_i.value == entry_q));

  // Insert takes the new value at the insert point and the lower neighbour
  // above it; delete takes the upper neighbour from the match onwards.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && shift_o) begin
      entry_d = prev_shift_i ? prev_entry_i : cmd_i.value;
    end else if (cmd_i.del_en && found_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
